// ----- design/pmct_pkg.sv -----
// Shared types and constants for the prefix match count table.
// No dependencies; every other design file refers to this package by scoped names.

package pmct_pkg;

    // Default sizes handed to the top level's parameters
    localparam int unsigned CAPACITY_DEF    = 64;
    localparam int unsigned MAX_LETTERS_DEF = 21;

    // Fixed field widths
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned POS_W    = 5;   // letter position and stored length
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // Token that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic                vld;
        logic                cmd;
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic [POS_W-1:0]    pos;
        logic                too_long;    // word has run past the letter limit
        logic                prev_valid;  // cell just upstream holds a stored name
        logic                committed;   // an upstream cell stored this add
        logic [COUNT_W-1:0]  count;       // running prefix match count
    } t_tok;

endpackage

// ----- design/prefix_match_count_table.sv -----
// Top level of the prefix match count table: front end plus a chain of entry cells.
// Depends on pmct_pkg, pmct_front and pmct_cell.
//
// Words arrive one letter per transaction (start high, busy low). Each letter
// becomes a token that walks down a chain of CAPACITY cells, one cell per
// cycle; every cell holds one stored name and updates its own match flag as
// the token passes. busy never rises, so a new letter may follow every cycle.
// A result comes only on a word's last letter and appears on o_match_count
// and o_status, with o_valid high for a single cycle, once the token has
// passed the front register and the CAPACITY cell registers. The receiver
// cannot stall; it must take each result in the cycle it is shown. An add
// that is stored reports status 0; a full table reports 1 and a name past
// MAX_LETTERS letters reports 2, and either case drops the name (full wins
// when both apply). A find reports how many stored names begin with its
// prefix, saturating at 127. No clearing pass is needed after reset; stored
// letters are written before use.

module prefix_match_count_table #(
    parameter int unsigned CAPACITY    = pmct_pkg::CAPACITY_DEF,
    parameter int unsigned MAX_LETTERS = pmct_pkg::MAX_LETTERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [pmct_pkg::LETTER_W-1:0]     i_letter,
    input  logic                              i_last,
    output logic                              o_valid,
    output logic [pmct_pkg::COUNT_W-1:0]      o_match_count,
    output logic [pmct_pkg::STATUS_W-1:0]     o_status
);

    // token entering each cell; index CAPACITY is what leaves the last one
    pmct_pkg::t_tok                                  tok     [CAPACITY+1];
    // letters a cell offers its downstream neighbor when it stores a name
    logic [MAX_LETTERS-1:0][pmct_pkg::LETTER_W-1:0]  letters [CAPACITY+1];
    logic                                            accept;
    pmct_pkg::t_tok                                  tail;

    // the chain keeps pace with the input, so no stall is ever needed
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    pmct_front #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .i_letter  (i_letter),
        .i_last    (i_last),
        .o_tok     (tok[0])
    );

    // nothing upstream of the first cell ever hands over letters
    assign letters[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pmct_cell #(
            .MAX_LETTERS (MAX_LETTERS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_tok          (tok[g]),
            .i_prev_letters (letters[g]),
            .o_tok          (tok[g+1]),
            .o_letters      (letters[g+1])
        );
    end

    // result decode from the token leaving the chain
    assign tail    = tok[CAPACITY];
    assign o_valid = tail.vld & tail.last;

    always_comb begin
        o_match_count = '0;
        o_status      = pmct_pkg::STATUS_OK;
        if (tail.cmd == pmct_pkg::CMD_FIND) begin
            o_match_count = tail.count;
        end else if (!tail.committed) begin
            // no cell took the name: last cell valid means the table is full
            o_status = tail.prev_valid ? pmct_pkg::STATUS_FULL : pmct_pkg::STATUS_TOO_LONG;
        end
    end

endmodule

// ----- design/pmct_front.sv -----
// Front end of the prefix match count table: letter position and overflow tracking.
// Depends on pmct_pkg; feeds the first cell of the chain.

module pmct_front #(
    parameter int unsigned MAX_LETTERS = pmct_pkg::MAX_LETTERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_command,
    input  logic [pmct_pkg::LETTER_W-1:0]     i_letter,
    input  logic                              i_last,
    output pmct_pkg::t_tok                    o_tok
);

    localparam logic [pmct_pkg::POS_W-1:0] POS_LIMIT = pmct_pkg::POS_W'(MAX_LETTERS);

    logic [pmct_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_too_long, n_too_long;
    logic                       too_long_now;
    pmct_pkg::t_tok             r_tok, n_tok;

    always_comb begin
        too_long_now = r_too_long |
                       ((i_command == pmct_pkg::CMD_ADD) && (r_pos >= POS_LIMIT));
        n_pos      = r_pos;
        n_too_long = r_too_long;
        if (i_accept) begin
            if (i_last) begin
                n_pos      = '0;
                n_too_long = 1'b0;
            end else begin
                if (r_pos < POS_LIMIT) begin
                    n_pos = r_pos + pmct_pkg::POS_W'(1);
                end
                n_too_long = too_long_now;
            end
        end

        n_tok            = '0;
        n_tok.vld        = i_accept;
        n_tok.cmd        = i_command;
        n_tok.letter     = i_letter;
        n_tok.last       = i_last;
        n_tok.pos        = r_pos;
        n_tok.too_long   = too_long_now;
        n_tok.prev_valid = 1'b1;    // nothing sits ahead of the first cell
        n_tok.committed  = 1'b0;
        n_tok.count      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_too_long <= 1'b0;
            r_tok      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_too_long <= n_too_long;
            r_tok      <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- design/pmct_cell.sv -----
// One table entry: stored letters, length, valid and match flags.
// Depends on pmct_pkg; instantiated in a chain by the top level.

module pmct_cell #(
    parameter int unsigned MAX_LETTERS = pmct_pkg::MAX_LETTERS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  pmct_pkg::t_tok                                    i_tok,
    input  logic [MAX_LETTERS-1:0][pmct_pkg::LETTER_W-1:0]    i_prev_letters,
    output pmct_pkg::t_tok                                    o_tok,
    output logic [MAX_LETTERS-1:0][pmct_pkg::LETTER_W-1:0]    o_letters
);

    localparam int unsigned IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam logic [pmct_pkg::POS_W-1:0] POS_LIMIT = pmct_pkg::POS_W'(MAX_LETTERS);

    logic                                            r_valid;
    logic                                            r_match, n_match;
    logic [pmct_pkg::POS_W-1:0]                      r_len;
    logic [MAX_LETTERS-1:0][pmct_pkg::LETTER_W-1:0]  r_letters, n_letters;
    pmct_pkg::t_tok                                  r_tok, n_tok;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             avail;
    logic             is_tgt;
    logic             do_copy;
    logic             is_add;
    logic             commit;
    logic             hit;
    logic             match_nxt;

    always_comb begin
        in_range = i_tok.pos < POS_LIMIT;
        idx      = i_tok.pos[IDX_W-1:0];
        is_add   = i_tok.cmd == pmct_pkg::CMD_ADD;
        // first empty cell; it doubles as the staging buffer
        avail    = i_tok.vld & i_tok.prev_valid & ~r_valid;
        is_tgt   = avail & ~i_tok.committed;
        // upstream neighbor just stored its name: inherit its staging letters
        do_copy  = avail & i_tok.committed;
        commit   = is_tgt & is_add & i_tok.last & ~i_tok.too_long;

        hit       = in_range && (i_tok.pos < r_len) && (r_letters[idx] == i_tok.letter);
        match_nxt = (i_tok.cmd == pmct_pkg::CMD_FIND) ? (r_match & hit) : r_match;

        n_match = r_match;
        if (i_tok.vld) begin
            n_match = i_tok.last ? 1'b1 : match_nxt;
        end

        n_letters = r_letters;
        if (do_copy) begin
            n_letters = i_prev_letters;
        end else if (is_tgt && is_add && in_range) begin
            n_letters[idx] = i_tok.letter;
        end

        n_tok            = i_tok;
        n_tok.prev_valid = r_valid | commit;
        n_tok.committed  = i_tok.committed | commit;
        if (i_tok.vld && (i_tok.cmd == pmct_pkg::CMD_FIND) && i_tok.last && r_valid &&
            match_nxt && (i_tok.count != pmct_pkg::COUNT_MAX)) begin
            n_tok.count = i_tok.count + pmct_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b1;
            r_tok   <= '0;
        end else begin
            if (commit) begin
                r_valid <= 1'b1;
            end
            r_match <= n_match;
            r_tok   <= n_tok;
        end
    end

    // entry contents, no reset
    always_ff @(posedge i_clk) begin
        r_letters <= n_letters;
        if (commit) begin
            r_len <= i_tok.pos + pmct_pkg::POS_W'(1);
        end
    end

    assign o_tok     = r_tok;
    assign o_letters = r_letters;

endmodule

// ----- design/pmct_checker.sv -----
// Port-level checks for prefix_match_count_table, attached by bind.
// Depends on pmct_pkg; sees only the top level's ports.

module pmct_checker #(
    parameter int unsigned CAPACITY = pmct_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_last,
    input logic                              o_valid,
    input logic [pmct_pkg::COUNT_W-1:0]      o_match_count,
    input logic [pmct_pkg::STATUS_W-1:0]     o_status
);

    localparam int unsigned LATENCY = CAPACITY + 1;

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    // a dropped add carries no match count
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pmct_pkg::STATUS_OK)) |-> (o_match_count == '0))
        else $error("nonzero count on dropped add");

    // every result follows an accepted last-letter transaction through the front and cell registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_last, LATENCY))
        else $error("result without matching last-letter transaction");

    // reset flushes the chain
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind prefix_match_count_table pmct_checker #(
    .CAPACITY (CAPACITY)
) u_pmct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last        (i_last),
    .o_valid       (o_valid),
    .o_match_count (o_match_count),
    .o_status      (o_status)
);
